@@ src/m3i_pkg.sv @@
package m3i_pkg;

    localparam int FRAC_SHIFT = 28;
    localparam int NUM_ELEM   = 9;
    localparam int ADJ_STAGES = 5;

    // adj[k] = a[PA]*a[PB] - a[QA]*a[QB], elements indexed row*3+col
    localparam int ADJ_PA [NUM_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
    localparam int ADJ_PB [NUM_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
    localparam int ADJ_QA [NUM_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
    localparam int ADJ_QB [NUM_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

endpackage

@@ src/m3i_in_if.sv @@
interface m3i_in_if #(
    parameter int IN_WIDTH = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] e00;
    logic signed [IN_WIDTH-1:0] e01;
    logic signed [IN_WIDTH-1:0] e02;
    logic signed [IN_WIDTH-1:0] e10;
    logic signed [IN_WIDTH-1:0] e11;
    logic signed [IN_WIDTH-1:0] e12;
    logic signed [IN_WIDTH-1:0] e20;
    logic signed [IN_WIDTH-1:0] e21;
    logic signed [IN_WIDTH-1:0] e22;

    modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                    input ready);
    modport sink (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                  output ready);
endinterface

@@ src/m3i_out_if.sv @@
interface m3i_out_if #(
    parameter int OUT_WIDTH = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] r00;
    logic signed [OUT_WIDTH-1:0] r01;
    logic signed [OUT_WIDTH-1:0] r02;
    logic signed [OUT_WIDTH-1:0] r10;
    logic signed [OUT_WIDTH-1:0] r11;
    logic signed [OUT_WIDTH-1:0] r12;
    logic signed [OUT_WIDTH-1:0] r20;
    logic signed [OUT_WIDTH-1:0] r21;
    logic signed [OUT_WIDTH-1:0] r22;
    logic                        singular;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, input ready);
    modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, output ready);
endinterface

@@ src/m3i_adj.sv @@
module m3i_adj #(
    parameter int IN_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [IN_WIDTH-1:0]     i_e [m3i_pkg::NUM_ELEM],
    output logic signed [2*IN_WIDTH:0]     o_adj [m3i_pkg::NUM_ELEM],
    output logic signed [3*IN_WIDTH+2:0]   o_det,
    output logic                           o_singular
);
    localparam int PW    = 2 * IN_WIDTH;
    localparam int ADJ_W = PW + 1;
    localparam int DPW   = IN_WIDTH + ADJ_W;
    localparam int DET_W = DPW + 2;
    localparam int NE    = m3i_pkg::NUM_ELEM;

    logic signed [IN_WIDTH-1:0] r_a1 [NE];
    logic signed [PW-1:0]       r_pp [NE];
    logic signed [PW-1:0]       r_pq [NE];
    logic signed [IN_WIDTH-1:0] r_a2 [3];
    logic signed [ADJ_W-1:0]    r_adj3 [NE];
    logic signed [IN_WIDTH-1:0] r_a3 [3];
    logic signed [DPW-1:0]      r_dp [3];
    logic signed [ADJ_W-1:0]    r_adj4 [NE];
    logic signed [ADJ_W-1:0]    r_adj5 [NE];
    logic signed [DET_W-1:0]    r_det;
    logic signed [DET_W-1:0]    n_det;
    logic                       r_sing;

    assign n_det = DET_W'(r_dp[0]) + DET_W'(r_dp[1]) + DET_W'(r_dp[2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NE; k++) begin
                r_a1[k]   <= i_e[k];
                r_pp[k]   <= PW'(r_a1[m3i_pkg::ADJ_PA[k]]) * PW'(r_a1[m3i_pkg::ADJ_PB[k]]);
                r_pq[k]   <= PW'(r_a1[m3i_pkg::ADJ_QA[k]]) * PW'(r_a1[m3i_pkg::ADJ_QB[k]]);
                r_adj3[k] <= ADJ_W'(r_pp[k]) - ADJ_W'(r_pq[k]);
                r_adj4[k] <= r_adj3[k];
                r_adj5[k] <= r_adj4[k];
            end
            for (int j = 0; j < 3; j++) begin
                r_a2[j] <= r_a1[j];
                r_a3[j] <= r_a2[j];
                r_dp[j] <= DPW'(r_a3[j]) * DPW'(r_adj3[3*j]);
            end
            r_det  <= n_det;
            r_sing <= (n_det == '0);
        end
    end

    assign o_adj      = r_adj5;
    assign o_det      = r_det;
    assign o_singular = r_sing;
endmodule

@@ src/m3i_div.sv @@
module m3i_div #(
    parameter int IN_WIDTH  = 16,
    parameter int OUT_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [2*IN_WIDTH:0]  i_adj,
    input  logic signed [3*IN_WIDTH+2:0] i_det,
    output logic signed [OUT_WIDTH-1:0] o_q
);
    localparam int ADJ_W = 2 * IN_WIDTH + 1;
    localparam int DET_W = 3 * IN_WIDTH + 3;
    localparam int NW    = ADJ_W + m3i_pkg::FRAC_SHIFT;
    localparam int CW    = (NW > DET_W) ? NW : DET_W;
    localparam int OW    = OUT_WIDTH;

    logic [ADJ_W-1:0]  mag_n;
    logic [DET_W-1:0]  mag_d;
    logic [NW-1:0]     num;
    logic [NW+OW-1:0]  num_ext;
    logic [NW-1:0]     hi;
    logic [CW-1:0]     hi_c;
    logic [CW-1:0]     ud_c;

    logic [DET_W-1:0] r_rem [OW+1];
    logic [OW-1:0]    r_q   [OW+1];
    logic [OW-1:0]    r_lo  [OW+1];
    logic [DET_W-1:0] r_ud  [OW+1];
    logic             r_neg [OW+1];
    logic             r_sat [OW+1];
    logic [DET_W:0]   trial [OW];

    logic [OW-1:0]    lim;
    logic [OW-1:0]    qq;
    logic [OW-1:0]    r_out;

    always_comb begin
        mag_n   = i_adj[ADJ_W-1] ? ADJ_W'(-i_adj) : ADJ_W'(i_adj);
        mag_d   = i_det[DET_W-1] ? DET_W'(-i_det) : DET_W'(i_det);
        num     = {mag_n, {m3i_pkg::FRAC_SHIFT{1'b0}}};
        num_ext = (NW+OW)'(num);
        hi      = num >> OW;
        hi_c    = CW'(hi);
        ud_c    = CW'(mag_d);
    end

    always_comb begin
        for (int s = 0; s < OW; s++) begin
            trial[s] = {r_rem[s], r_lo[s][OW-1]};
        end
    end

    always_comb begin
        lim = r_neg[OW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        qq  = (r_sat[OW] || r_q[OW] > lim) ? lim : r_q[OW];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DET_W'(hi_c);
            r_q[0]   <= '0;
            r_lo[0]  <= num_ext[OW-1:0];
            r_ud[0]  <= mag_d;
            r_neg[0] <= i_adj[ADJ_W-1] ^ i_det[DET_W-1];
            r_sat[0] <= (hi_c >= ud_c);
            for (int s = 0; s < OW; s++) begin
                if (trial[s] >= {1'b0, r_ud[s]}) begin
                    r_rem[s+1] <= DET_W'(trial[s] - {1'b0, r_ud[s]});
                    r_q[s+1]   <= {r_q[s][OW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= trial[s][DET_W-1:0];
                    r_q[s+1]   <= {r_q[s][OW-2:0], 1'b0};
                end
                r_lo[s+1]  <= {r_lo[s][OW-2:0], 1'b0};
                r_ud[s+1]  <= r_ud[s];
                r_neg[s+1] <= r_neg[s];
                r_sat[s+1] <= r_sat[s];
            end
            r_out <= r_neg[OW] ? OW'(-qq) : qq;
        end
    end

    assign o_q = r_out;
endmodule

@@ src/matrix3x3_inverse_top.sv @@
// 3x3 matrix inverse, streaming
// i_in carries one request per accepted cycle: nine signed Q3.12 elements,
// row-major e00..e22. o_out returns one result per request: the inverse as
// nine signed Q15.16 values r00..r22, truncated toward zero and saturated,
// plus singular, which is set (with all entries zero) when the determinant
// is zero. Both channels use valid/ready; a transfer happens when both are
// high. Results come out in request order.
// Throughput: one request per cycle unless o_out stalls. The pipeline has
// five stages of multiplies and adds for the adjugate and determinant,
// one setup stage, one restoring divide stage per quotient bit in each of
// nine divider lanes, and one saturation stage.
// The whole pipeline advances together: while a result is held on o_out
// with ready low, i_in.ready drops and every stage holds its contents, so
// nothing is lost or repeated. Synchronous active-low reset clears all
// valid bits; datapath registers are not reset.
module matrix3x3_inverse_top #(
    parameter int IN_WIDTH  = 16,
    parameter int OUT_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    m3i_in_if.sink    i_in,
    m3i_out_if.source o_out
);
    localparam int ADJ_W = 2 * IN_WIDTH + 1;
    localparam int DET_W = 3 * IN_WIDTH + 3;
    localparam int NE    = m3i_pkg::NUM_ELEM;
    localparam int DIVL  = OUT_WIDTH + 2;
    localparam int LAT   = m3i_pkg::ADJ_STAGES + DIVL;

    logic                        en;
    logic signed [IN_WIDTH-1:0]  e [NE];
    logic signed [ADJ_W-1:0]     adj [NE];
    logic signed [DET_W-1:0]     det;
    logic                        sing;
    logic signed [OUT_WIDTH-1:0] q [NE];
    logic [LAT-1:0]              r_vld;
    logic [DIVL-1:0]             r_sing;

    assign en = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = en;

    assign e[0] = i_in.e00;
    assign e[1] = i_in.e01;
    assign e[2] = i_in.e02;
    assign e[3] = i_in.e10;
    assign e[4] = i_in.e11;
    assign e[5] = i_in.e12;
    assign e[6] = i_in.e20;
    assign e[7] = i_in.e21;
    assign e[8] = i_in.e22;

    m3i_adj #(.IN_WIDTH(IN_WIDTH)) u_adj (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_e        (e),
        .o_adj      (adj),
        .o_det      (det),
        .o_singular (sing)
    );

    for (genvar k = 0; k < NE; k++) begin : g_div
        m3i_div #(.IN_WIDTH(IN_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_adj (adj[k]),
            .i_det (det),
            .o_q   (q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing <= {r_sing[DIVL-2:0], sing};
        end
    end

    assign o_out.valid    = r_vld[LAT-1];
    assign o_out.singular = r_sing[DIVL-1];
    assign o_out.r00 = r_sing[DIVL-1] ? '0 : q[0];
    assign o_out.r01 = r_sing[DIVL-1] ? '0 : q[1];
    assign o_out.r02 = r_sing[DIVL-1] ? '0 : q[2];
    assign o_out.r10 = r_sing[DIVL-1] ? '0 : q[3];
    assign o_out.r11 = r_sing[DIVL-1] ? '0 : q[4];
    assign o_out.r12 = r_sing[DIVL-1] ? '0 : q[5];
    assign o_out.r20 = r_sing[DIVL-1] ? '0 : q[6];
    assign o_out.r21 = r_sing[DIVL-1] ? '0 : q[7];
    assign o_out.r22 = r_sing[DIVL-1] ? '0 : q[8];

`ifndef SYNTHESIS
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without output backpressure");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted request lost at pipeline entry");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.r00)
            && $stable(o_out.singular)))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif
endmodule
